>>> rtl/core/pidv_pkg.sv
// ----------------------------------------------------------------------------
// pidv_pkg
// Shared widths, register indexes, reset values and constants for the
// incremental pid regulator with variable-speed integration.
// ----------------------------------------------------------------------------
package pidv_pkg;

  // field and register widths
  localparam int LVL_W   = 16;  // voltage samples and setpoint, Q6.10
  localparam int GAIN_W  = 16;  // gains, unsigned Q8.8
  localparam int LIM_W   = 15;  // clamp limits, Q.10
  localparam int ERR_W   = 17;  // signed error
  localparam int D1_W    = 18;  // first difference of errors
  localparam int D2_W    = 19;  // second difference of errors
  localparam int MAG_W   = 16;  // |error|
  localparam int WT_W    = 16;  // integral weight, Q0.16
  localparam int WE_W    = 16;  // clamped weighted error, signed
  localparam int DRV_W   = 16;  // controller output, signed Q.10
  localparam int CFG_A_W = 3;

  // shared multiplier operand widths
  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = 20;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SUM_W   = 36;  // Q.18 sum of the three increments

  // register indexes
  localparam logic [CFG_A_W-1:0] REG_TARGET = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_PGAIN  = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_IGAIN  = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_DGAIN  = 3'd3;
  localparam logic [CFG_A_W-1:0] REG_ILIM   = 3'd4;
  localparam logic [CFG_A_W-1:0] REG_DLIM   = 3'd5;

  // register reset values
  localparam logic [LVL_W-1:0]  RST_TARGET = 16'd13312;
  localparam logic [GAIN_W-1:0] RST_PGAIN  = 16'd768;
  localparam logic [GAIN_W-1:0] RST_IGAIN  = 16'd26;
  localparam logic [GAIN_W-1:0] RST_DGAIN  = 16'd0;
  localparam logic [LIM_W-1:0]  RST_ILIM   = 15'd5120;
  localparam logic [LIM_W-1:0]  RST_DLIM   = 15'd20480;

  // weight divide: C = 5120 * 65536 / (5120 + |e|)
  localparam int DIVD_W    = 29;
  localparam int DVSR_W    = 17;
  localparam int QUO_W     = 17;  // quotient never reaches 2^17
  localparam int DIV_STEPS = QUO_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
  localparam logic [DIVD_W-1:0] DIV_DIVIDEND = 29'd335544320;
  localparam logic [DVSR_W-1:0] DIV_BASE     = 17'd5120;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/core/pidv_div.sv
// ----------------------------------------------------------------------------
// pidv_div
// Restoring divider for the integral weight: a fixed dividend over a
// 17-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidv_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [pidv_pkg::DVSR_W-1:0]     divisor,
  output logic [pidv_pkg::QUO_W-1:0]      quotient,
  output pidv_pkg::div_stat_t             stat
);

  logic [pidv_pkg::DVSR_W-1:0]    rem_r, rem_nxt;
  logic [pidv_pkg::QUO_W-1:0]     low_r, low_nxt;
  logic [pidv_pkg::DVSR_W-1:0]    dvsr_r;
  logic [pidv_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           done_r;
  logic [pidv_pkg::DVSR_W:0]      trial;
  logic                           ge;

  // one trial subtract per cycle, quotient bits shift into the low word
  always_comb begin
    trial   = {rem_r, low_r[pidv_pkg::QUO_W-1]};
    ge      = (trial >= {1'b0, dvsr_r});
    rem_nxt = ge ? pidv_pkg::DVSR_W'(trial - {1'b0, dvsr_r})
                 : trial[pidv_pkg::DVSR_W-1:0];
    low_nxt = {low_r[pidv_pkg::QUO_W-2:0], ge};
  end

  // upper dividend bits preload the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= pidv_pkg::DVSR_W'(pidv_pkg::DIV_DIVIDEND[pidv_pkg::DIVD_W-1:pidv_pkg::QUO_W]);
      low_r  <= pidv_pkg::DIV_DIVIDEND[pidv_pkg::QUO_W-1:0];
      dvsr_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
    end
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == pidv_pkg::DIV_CNT_W'(1));
      if (start) begin
        cnt_r <= pidv_pkg::DIV_CNT_W'(pidv_pkg::DIV_STEPS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - pidv_pkg::DIV_CNT_W'(1);
      end
    end
  end

  assign quotient  = low_r;
  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;

endmodule

>>> rtl/core/pidv_mul.sv
// ----------------------------------------------------------------------------
// pidv_mul
// Shared signed multiplier with a registered product, used for the weight
// product and for each of the three gain products in turn.
// ----------------------------------------------------------------------------
module pidv_mul (
  input  logic                                clk,
  input  logic signed [pidv_pkg::MUL_A_W-1:0] op_a,
  input  logic signed [pidv_pkg::MUL_B_W-1:0] op_b,
  output logic signed [pidv_pkg::PROD_W-1:0]  prod
);

  logic signed [pidv_pkg::PROD_W-1:0] prod_r;

  // product register
  always_ff @(posedge clk) begin
    prod_r <= pidv_pkg::PROD_W'(op_a) * pidv_pkg::PROD_W'(op_b);
  end

  assign prod = prod_r;

endmodule

>>> rtl/core/incremental_pid_variable_integral.sv
// ----------------------------------------------------------------------------
// incremental_pid_variable_integral
// Incremental pid voltage regulator with variable-speed integration.
// ----------------------------------------------------------------------------
// Each word on the in_ channel is one measured voltage sample (unsigned
// Q6.10). The block forms the error against target_level, weights it by
// C = 1/(1 + |e|/5120) through a bit-serial divider, clamps the weighted
// error, adds the P, I and D increments to the running output, clamps that
// and sends it as one word on the out_ channel (signed Q.10).
// From accept to out_tvalid the work passes through the divider start,
// the divider steps and finish, four passes through one shared
// multiplier and the final add and clamp. One sample is in work at a time
// and a new word is not taken until the last one is through; in_tready
// is high only while idle.
// The result sits in an output register; the next sample may be accepted
// while it waits, but the next running-output update holds until the
// receiver takes the previous word.
// Reset (rst_n low, synchronous) restores all register defaults and clears
// the error history and the running output.
// Configuration writes via cfg_wr_en/cfg_addr/cfg_wr_data take effect at
// once; indexes above 5 are ignored.
// ----------------------------------------------------------------------------
module incremental_pid_variable_integral (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: measured_level[15:0]
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,
  // out_tdata: drive_value[15:0]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,
  input  logic                          cfg_wr_en,
  input  logic [pidv_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [15:0]                   cfg_wr_data
);

  // sequencer codes
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIVS = 4'd1;
  localparam logic [3:0] ST_DIV  = 4'd2;
  localparam logic [3:0] ST_MW   = 4'd3;
  localparam logic [3:0] ST_WF   = 4'd4;
  localparam logic [3:0] ST_MP   = 4'd5;
  localparam logic [3:0] ST_MI   = 4'd6;
  localparam logic [3:0] ST_MD   = 4'd7;
  localparam logic [3:0] ST_MS   = 4'd8;
  localparam logic [3:0] ST_UPD  = 4'd9;

  localparam int SHR_W = pidv_pkg::SUM_W - 8;
  localparam int UPD_W = SHR_W + 1;

  logic [3:0] state_r, state_nxt;

  // configuration registers
  logic [pidv_pkg::LVL_W-1:0]  target_r;
  logic [pidv_pkg::GAIN_W-1:0] pgain_r, igain_r, dgain_r;
  logic [pidv_pkg::LIM_W-1:0]  ilim_r, dlim_r;

  // loop state and working registers
  logic signed [pidv_pkg::ERR_W-1:0] err_now_r, err_prev_r, err_prev2_r;
  logic signed [pidv_pkg::DRV_W-1:0] drive_r;
  logic [pidv_pkg::MAG_W-1:0]        mag_r;
  logic                              neg_r;
  logic signed [pidv_pkg::D1_W-1:0]  d1_r;
  logic signed [pidv_pkg::D2_W-1:0]  d2_r;
  logic [pidv_pkg::WT_W-1:0]         wt_r;
  logic signed [pidv_pkg::WE_W-1:0]  we_r;
  logic signed [pidv_pkg::SUM_W-1:0] acc_r;
  logic                              out_valid_r;
  logic [15:0]                       out_data_r;

  logic                              in_acc;
  logic                              out_free;
  logic signed [pidv_pkg::ERR_W-1:0] err_in;
  logic signed [pidv_pkg::ERR_W-1:0] err_neg;

  logic                              div_start;
  logic [pidv_pkg::DVSR_W-1:0]       div_dvsr;
  logic [pidv_pkg::QUO_W-1:0]        div_quo;
  pidv_pkg::div_stat_t               div_stat;

  logic signed [pidv_pkg::MUL_A_W-1:0] mul_a;
  logic signed [pidv_pkg::MUL_B_W-1:0] mul_b;
  logic signed [pidv_pkg::PROD_W-1:0]  prod;

  logic [pidv_pkg::MAG_W:0]          wmag;
  logic [pidv_pkg::MAG_W:0]          wclip;
  logic signed [pidv_pkg::WE_W-1:0]  we_nxt;
  logic signed [UPD_W-1:0]           upd_sum;
  logic signed [UPD_W-1:0]           dlim_s;
  logic signed [pidv_pkg::DRV_W-1:0] drive_nxt;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_tready;

  // error and its magnitude at accept
  assign err_in  = $signed({1'b0, target_r}) - $signed({1'b0, in_tdata});
  assign err_neg = -err_in;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= pidv_pkg::RST_TARGET;
      pgain_r  <= pidv_pkg::RST_PGAIN;
      igain_r  <= pidv_pkg::RST_IGAIN;
      dgain_r  <= pidv_pkg::RST_DGAIN;
      ilim_r   <= pidv_pkg::RST_ILIM;
      dlim_r   <= pidv_pkg::RST_DLIM;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        pidv_pkg::REG_TARGET: target_r <= cfg_wr_data;
        pidv_pkg::REG_PGAIN:  pgain_r  <= cfg_wr_data;
        pidv_pkg::REG_IGAIN:  igain_r  <= cfg_wr_data;
        pidv_pkg::REG_DGAIN:  dgain_r  <= cfg_wr_data;
        pidv_pkg::REG_ILIM:   ilim_r   <= cfg_wr_data[pidv_pkg::LIM_W-1:0];
        pidv_pkg::REG_DLIM:   dlim_r   <= cfg_wr_data[pidv_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // weight divider
  assign div_start = (state_r == ST_DIVS);
  assign div_dvsr  = pidv_pkg::DIV_BASE + pidv_pkg::DVSR_W'(mag_r);

  pidv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (div_dvsr),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // operand select for the shared multiplier
  always_comb begin
    unique case (state_r)
      ST_MW: begin
        mul_a = $signed(pidv_pkg::MUL_A_W'(wt_r));
        mul_b = $signed(pidv_pkg::MUL_B_W'(mag_r));
      end
      ST_MP: begin
        mul_a = $signed(pidv_pkg::MUL_A_W'(pgain_r));
        mul_b = pidv_pkg::MUL_B_W'(d1_r);
      end
      ST_MI: begin
        mul_a = $signed(pidv_pkg::MUL_A_W'(igain_r));
        mul_b = pidv_pkg::MUL_B_W'(we_r);
      end
      ST_MD: begin
        mul_a = $signed(pidv_pkg::MUL_A_W'(dgain_r));
        mul_b = pidv_pkg::MUL_B_W'(d2_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pidv_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // weighted error: magnitude clamp then sign
  always_comb begin
    wmag   = prod[pidv_pkg::MAG_W+16:16];
    wclip  = (wmag > (pidv_pkg::MAG_W+1)'(ilim_r)) ? (pidv_pkg::MAG_W+1)'(ilim_r) : wmag;
    we_nxt = neg_r ? -$signed(pidv_pkg::WE_W'(wclip)) : $signed(pidv_pkg::WE_W'(wclip));
  end

  // running output update: floor of the Q.18 sum, then clamp
  always_comb begin
    upd_sum = UPD_W'(drive_r) + UPD_W'($signed(acc_r[pidv_pkg::SUM_W-1:8]));
    dlim_s  = $signed(UPD_W'(dlim_r));
    priority if (upd_sum > dlim_s) begin
      drive_nxt = pidv_pkg::DRV_W'(dlim_s);
    end else if (upd_sum < -dlim_s) begin
      drive_nxt = pidv_pkg::DRV_W'(-dlim_s);
    end else begin
      drive_nxt = upd_sum[pidv_pkg::DRV_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_DIVS;
      ST_DIVS: state_nxt = ST_DIV;
      ST_DIV:  if (div_stat.done) state_nxt = ST_MW;
      ST_MW:   state_nxt = ST_WF;
      ST_WF:   state_nxt = ST_MP;
      ST_MP:   state_nxt = ST_MI;
      ST_MI:   state_nxt = ST_MD;
      ST_MD:   state_nxt = ST_MS;
      ST_MS:   state_nxt = ST_UPD;
      ST_UPD:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state, error history and running output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      err_now_r   <= '0;
      err_prev_r  <= '0;
      err_prev2_r <= '0;
      drive_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        err_prev2_r <= err_prev_r;
        err_prev_r  <= err_now_r;
        err_now_r   <= err_in;
      end
      // a new word replaces the taken one, otherwise the handshake clears it
      if (state_r == ST_UPD && out_free) begin
        drive_r     <= drive_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mag_r <= err_in[pidv_pkg::ERR_W-1] ? err_neg[pidv_pkg::MAG_W-1:0]
                                         : err_in[pidv_pkg::MAG_W-1:0];
      neg_r <= err_in[pidv_pkg::ERR_W-1];
    end
    if (state_r == ST_DIVS) begin
      d1_r <= pidv_pkg::D1_W'(err_now_r) - pidv_pkg::D1_W'(err_prev_r);
      d2_r <= pidv_pkg::D2_W'(err_now_r) - (pidv_pkg::D2_W'(err_prev_r) <<< 1)
              + pidv_pkg::D2_W'(err_prev2_r);
    end
    // zero error gives 1.0, which saturates to the largest Q0.16 code
    if (state_r == ST_DIV && div_stat.done) begin
      wt_r <= div_quo[pidv_pkg::QUO_W-1] ? '1 : div_quo[pidv_pkg::WT_W-1:0];
    end
    if (state_r == ST_WF) begin
      we_r <= we_nxt;
    end
    if (state_r == ST_MI) begin
      acc_r <= prod[pidv_pkg::SUM_W-1:0];
    end else if (state_r == ST_MD || state_r == ST_MS) begin
      acc_r <= acc_r + prod[pidv_pkg::SUM_W-1:0];
    end
    if (state_r == ST_UPD && out_free) begin
      out_data_r <= drive_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIVS |=> div_stat.busy)
    else $error("divider did not start");

  a_out_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_UPD)
    else $error("result word raised outside the update step");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_stat.busy)
    else $error("ready while the divider is busy");

endmodule

>>> tb/tb_incremental_pid_variable_integral.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_incremental_pid_variable_integral
// Self-checking bench for the incremental pid regulator with variable-speed
// integration. A scoreboard predicts the drive value for every accepted
// voltage sample and checks the returned words in order. Stimulus starts
// with directed extremes and moves on to random samples under several
// register settings, with random idling on both channels and back-pressure.
// ----------------------------------------------------------------------------
module tb_incremental_pid_variable_integral;
  import pidv_pkg::*;

  // indexes past the register list, writes there must be dropped
  localparam logic [CFG_A_W-1:0] REG_SPARE6 = 3'd6;
  localparam logic [CFG_A_W-1:0] REG_SPARE7 = 3'd7;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int LONG_HOLD   = 300;

  // predicts the regulator output and holds the drive words still to come
  class pid_drive_scoreboard;
    logic [LVL_W-1:0]        target_level;
    logic [GAIN_W-1:0]       prop_gain;
    logic [GAIN_W-1:0]       integ_gain;
    logic [GAIN_W-1:0]       deriv_gain;
    logic [LIM_W-1:0]        integ_limit;
    logic [LIM_W-1:0]        drive_limit;
    int                      err_cur;
    int                      err_last;
    int                      err_last2;
    int                      drive_acc;
    logic signed [DRV_W-1:0] expected_drive[$];
    int                      fail_count;

    function void reset_model();
      target_level = RST_TARGET;
      prop_gain    = RST_PGAIN;
      integ_gain   = RST_IGAIN;
      deriv_gain   = RST_DGAIN;
      integ_limit  = RST_ILIM;
      drive_limit  = RST_DLIM;
      err_cur      = 0;
      err_last     = 0;
      err_last2    = 0;
      drive_acc    = 0;
    endfunction

    function void write_reg(logic [CFG_A_W-1:0] idx, logic [15:0] val);
      case (idx)
        REG_TARGET: target_level = val;
        REG_PGAIN:  prop_gain    = val;
        REG_IGAIN:  integ_gain   = val;
        REG_DGAIN:  deriv_gain   = val;
        REG_ILIM:   integ_limit  = val[LIM_W-1:0];
        REG_DLIM:   drive_limit  = val[LIM_W-1:0];
        default: ;
      endcase
    endfunction

    // one sample in, one drive word expected
    function void note_level(logic [LVL_W-1:0] lvl);
      int          mag;
      int unsigned wt;
      longint      wterm;
      longint      sum;
      longint      acc;
      err_last2 = err_last;
      err_last  = err_cur;
      err_cur   = int'(target_level) - int'(lvl);
      mag = (err_cur < 0) ? -err_cur : err_cur;
      // integral weight in Q0.16, saturates at zero error
      wt = 32'd335544320 / (32'd5120 + 32'(mag));
      if (wt > 32'd65535)
        wt = 32'd65535;
      wterm = longint'((64'(wt) * 64'(mag)) >> 16);
      if (err_cur < 0)
        wterm = -wterm;
      if (wterm > longint'(integ_limit))
        wterm = longint'(integ_limit);
      if (wterm < -longint'(integ_limit))
        wterm = -longint'(integ_limit);
      sum = longint'(prop_gain) * longint'(err_cur - err_last)
          + longint'(integ_gain) * wterm
          + longint'(deriv_gain) * longint'(err_cur - 2 * err_last + err_last2);
      // floor to Q.10, then saturate the running output
      acc = longint'(drive_acc) + (sum >>> 8);
      if (acc > longint'(drive_limit))
        acc = longint'(drive_limit);
      if (acc < -longint'(drive_limit))
        acc = -longint'(drive_limit);
      drive_acc = int'(acc);
      expected_drive.push_back(DRV_W'(drive_acc));
    endfunction

    function void check_drive(logic [DRV_W-1:0] got);
      logic signed [DRV_W-1:0] exp_val;
      if (expected_drive.size() == 0) begin
        $error("drive_value: unexpected word, actual %0d", $signed(got));
        fail_count++;
        return;
      end
      exp_val = expected_drive.pop_front();
      if (got !== exp_val) begin
        $error("drive_value mismatch: expected %0d, actual %0d", exp_val, $signed(got));
        fail_count++;
      end
    endfunction

    function int pending();
      return expected_drive.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [15:0]         in_tdata;    // measured_level[15:0]
  logic                out_tvalid;
  logic                out_tready;
  logic [15:0]         out_tdata;   // drive_value[15:0]
  logic                cfg_wr_en;
  logic [CFG_A_W-1:0]  cfg_addr;
  logic [15:0]         cfg_wr_data;

  pid_drive_scoreboard sb;
  bit                  gap_on;
  bit                  stall_on;
  int                  hold_len;

  incremental_pid_variable_integral u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_drive(out_tdata);
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int n;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_len != 0) begin
        n = hold_len;
        hold_len = 0;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // offer one sample and wait for it to be taken
  task automatic send_level(input logic [LVL_W-1:0] lvl);
    in_tvalid <= 1'b1;
    in_tdata  <= lvl;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_level(lvl);
    if (gap_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // stop offering and wait for every outstanding drive word
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_A_W-1:0] idx, input logic [15:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_addr    <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 4))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(0, 1023));
      default: return 16'($urandom);
    endcase
  endfunction

  // bit 15 is set or random in most picks, so the limit masking gets exercised
  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 4))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 2047));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_target();
    case ($urandom_range(0, 4))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // sample at or around the setpoint half of the time, so the loop can settle
  function automatic logic [LVL_W-1:0] pick_level();
    int v;
    case ($urandom_range(0, 5))
      0: return sb.target_level;
      1, 2: begin
        v = int'(sb.target_level) + int'($urandom_range(0, 512)) - 256;
        if (v < 0)
          v = 0;
        if (v > 65535)
          v = 65535;
        return LVL_W'(v);
      end
      3:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return LVL_W'($urandom);
    endcase
  endfunction

  // stimulus
  initial begin
    logic [LVL_W-1:0] reset_levels[12];
    logic [LVL_W-1:0] max_levels[6];
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_wr_en   = 1'b0;
    cfg_addr    = '0;
    cfg_wr_data = '0;
    rst_n       = 1'b0;
    gap_on      = 1'b0;
    stall_on    = 1'b0;
    hold_len    = 0;
    reset_levels = '{16'd0, 16'hFFFF, 16'd13312, 16'd13312, 16'd13313, 16'd13311,
                     16'h5555, 16'hAAAA, 16'd0, 16'hFFFF, 16'd1, 16'hFFFE};
    max_levels   = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'h8000, 16'hFFFF};
    sb = new();
    sb.fail_count = 0;
    sb.reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: extremes, zero error and small errors
    foreach (reset_levels[i])
      send_level(reset_levels[i]);
    wait_idle();

    // every register at its top, limits written with the spare top bit set
    cfg_write(REG_TARGET, 16'hFFFF);
    cfg_write(REG_PGAIN, 16'hFFFF);
    cfg_write(REG_IGAIN, 16'hFFFF);
    cfg_write(REG_DGAIN, 16'hFFFF);
    cfg_write(REG_ILIM, 16'hFFFF);
    cfg_write(REG_DLIM, 16'hFFFF);
    cfg_write(REG_SPARE6, 16'($urandom));
    cfg_write(REG_SPARE7, 16'($urandom));
    foreach (max_levels[i])
      send_level(max_levels[i]);
    wait_idle();

    // limits lowered under a saturated output, no weighted error allowed
    cfg_write(REG_TARGET, 16'd0);
    cfg_write(REG_PGAIN, 16'd0);
    cfg_write(REG_DGAIN, 16'd0);
    cfg_write(REG_ILIM, 16'd0);
    cfg_write(REG_DLIM, 16'd100);
    send_level(16'd0);
    send_level(16'hFFFF);
    send_level(16'd1234);
    send_level(16'd0);
    wait_idle();

    // random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      cfg_write(REG_TARGET, pick_target());
      cfg_write(REG_PGAIN, pick_gain());
      cfg_write(REG_IGAIN, pick_gain());
      cfg_write(REG_DGAIN, pick_gain());
      cfg_write(REG_ILIM, pick_limit());
      cfg_write(REG_DLIM, pick_limit());
      if ($urandom_range(0, 2) == 0)
        cfg_write($urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7, 16'($urandom));
      gap_on   = (ph < PHASES - 1) && $urandom_range(0, 3) != 0;
      stall_on = (ph < PHASES - 1) && $urandom_range(0, 3) != 0;
      if (ph == 2)
        hold_len = LONG_HOLD;
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_level(pick_level());
      wait_idle();
    end

    // let any stray word show up before the verdict
    repeat (40) @(posedge clk);
    if (sb.fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
